/* rtl/tfh_pkg.sv */
package tfh_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 15;
    localparam int COUNT_W  = 5;
    localparam int DUTY_W   = 8;
    localparam int KICK_W   = 10;
    localparam int TEMP_W   = 11;
    localparam int MID_W    = 6;
    localparam int MARGIN_W = 8;
    localparam int HYST_W   = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BELOW       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABOVE       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MED    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_TICKS  = 8'd7;

    // Register reset values
    localparam int RST_MIDPOINT   = 26;
    localparam int RST_BELOW      = 30;
    localparam int RST_ABOVE      = 40;
    localparam int RST_HYSTERESIS = 5;
    localparam int RST_DUTY_LOW   = 85;
    localparam int RST_DUTY_MED   = 170;
    localparam int RST_DUTY_HIGH  = 255;
    localparam int RST_KICK_TICKS = 300;

    // Samples per reading
    localparam int SAMPLES_PER_READING = 20;

    // Conversion: t = sum * TEMP_SCALE / (count * ADC_FULL)
    localparam int SAMPLE_MIN = 3;
    localparam int SAMPLE_MAX = 1020;
    localparam int TEMP_SCALE = 5000;
    localparam int ADC_FULL   = 1023;
    localparam int TEMP_LIMIT = 1500;
    localparam int DEG_TENTHS = 10;

    // Numerator sum*5000 and denominator count*1023 widths
    localparam int NUM_W = 28;
    localparam int DEN_W = 15;
    // Samples never exceed 1019, so the quotient stays below 5000
    localparam int QUOT_W      = 13;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Band decision arithmetic (signed tenths)
    localparam int BAND_W     = 14;
    localparam int BAND_MED   = 100;
    localparam int BAND_HIGH  = 200;
    localparam int BAND_FULL  = 210;
    localparam int DUTY_FULL  = 255;

    typedef struct packed {
        logic [MID_W-1:0]    midpoint_deg;
        logic [MARGIN_W-1:0] below_margin_tenths;
        logic [MARGIN_W-1:0] above_margin_tenths;
        logic [HYST_W-1:0]   hysteresis_tenths;
        logic [DUTY_W-1:0]   fan_duty_low;
        logic [DUTY_W-1:0]   fan_duty_med;
        logic [DUTY_W-1:0]   fan_duty_high;
        logic [KICK_W-1:0]   kick_ticks;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic tick;      // accepted tick request
        logic sample;    // accepted sample request
        logic mul_load;  // form numerator and shifted divisor
        logic div_step;  // one restoring division step
        logic finish;    // decide and publish the reading
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_sample;  // current sample closes a reading
        logic out_free;     // result register can take a new result
    } status_t;

endpackage

/* rtl/tfh_ctrl.sv */
module tfh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_func,
    output logic              s_ready,
    input  tfh_pkg::status_t  status,
    output tfh_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DECIDE
    } state_t;

    state_t                          state_reg, state_next;
    logic [tfh_pkg::DIV_CNT_W-1:0]   count_reg, count_next;
    logic                            accept;

    assign s_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept  = s_valid && s_ready;

    // Commands to the datapath
    always_comb begin
        cmd          = '0;
        cmd.tick     = accept && s_func;
        cmd.sample   = accept && !s_func;
        cmd.mul_load = (state_reg == ST_MUL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.finish   = (state_reg == ST_DECIDE) && status.out_free;
    end

    // Sequencing of one reading
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.sample && status.last_sample) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
                count_next = '0;
            end
            ST_DIV: begin
                count_next = count_reg + 1'b1;
                if (count_reg == tfh_pkg::DIV_CNT_W'(tfh_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/tfh_dp.sv */
module tfh_dp #(
    parameter int SAMPLES_PER_READING = tfh_pkg::SAMPLES_PER_READING
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tfh_pkg::cmd_t                    cmd,
    output tfh_pkg::status_t                 status,
    input  tfh_pkg::cfg_t                    cfg,
    input  logic [tfh_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic                             m_heater_on,
    output logic [tfh_pkg::DUTY_W-1:0]       m_fan_duty,
    output logic [tfh_pkg::TEMP_W-1:0]       m_temperature_tenths,
    output logic                             m_reading_done,
    output logic                             m_sensor_error
);

    localparam int BW = tfh_pkg::BAND_W;

    // Accumulator and controller state
    logic [tfh_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [tfh_pkg::COUNT_W-1:0]  vcount_reg, vcount_next;
    logic [tfh_pkg::COUNT_W-1:0]  index_reg, index_next;
    logic                         heater_reg, heater_next;
    logic [tfh_pkg::DUTY_W-1:0]   fan_reg, fan_next;
    logic [tfh_pkg::KICK_W-1:0]   kick_reg, kick_next;
    logic [tfh_pkg::TEMP_W-1:0]   temp_reg, temp_next;
    logic                         error_reg, error_next;

    // Divider
    logic [tfh_pkg::NUM_W-1:0]    rem_reg, rem_next;
    logic [tfh_pkg::NUM_W-1:0]    dsh_reg, dsh_next;
    logic [tfh_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [tfh_pkg::DEN_W-1:0]    den;

    // Result register
    logic                         m_valid_reg, m_valid_next;
    logic                         out_heater_reg;
    logic [tfh_pkg::DUTY_W-1:0]   out_fan_reg;
    logic [tfh_pkg::TEMP_W-1:0]   out_temp_reg;
    logic                         out_done_reg;
    logic                         out_error_reg;
    logic                         load_out;
    logic                         done_flag;

    logic                         sample_ok;
    logic [tfh_pkg::COUNT_W-1:0]  index_inc;

    // Band decision
    logic                         bad;
    logic                         apply;
    logic                         heat_d;
    logic [tfh_pkg::DUTY_W-1:0]   fan_d;
    logic [9:0]                   mid10;
    logic signed [BW-1:0]         ts, tmin, tmax, hy;

    assign sample_ok = (s_sample > tfh_pkg::SAMPLE_W'(tfh_pkg::SAMPLE_MIN))
                    && (s_sample < tfh_pkg::SAMPLE_W'(tfh_pkg::SAMPLE_MAX));
    assign index_inc = index_reg + 1'b1;

    assign status.last_sample = (index_inc >= tfh_pkg::COUNT_W'(SAMPLES_PER_READING));
    assign status.out_free    = !m_valid_reg || m_ready;

    assign den = (tfh_pkg::DEN_W'(vcount_reg) * tfh_pkg::DEN_W'(tfh_pkg::ADC_FULL));

    // Limits in signed tenths
    always_comb begin
        mid10 = 10'(cfg.midpoint_deg) * 10'(tfh_pkg::DEG_TENTHS);
        ts    = $signed(BW'(quot_reg));
        hy    = $signed(BW'(cfg.hysteresis_tenths));
        tmin  = $signed(BW'(mid10)) - $signed(BW'(cfg.below_margin_tenths));
        tmax  = $signed(BW'(mid10)) + $signed(BW'(cfg.above_margin_tenths));
    end

    // Band chain, first match wins; a bad reading turns heater and fan off; no match holds the outputs
    always_comb begin
        bad    = (vcount_reg == '0) || (quot_reg > tfh_pkg::QUOT_W'(tfh_pkg::TEMP_LIMIT));
        apply  = 1'b1;
        heat_d = 1'b0;
        fan_d  = '0;
        if (bad) begin
            heat_d = 1'b0;
        end else if (ts <= tmin - hy) begin
            heat_d = 1'b1;
        end else if ((ts > tmin + hy) && (ts <= tmax - hy)) begin
            heat_d = 1'b0;
        end else if ((ts > tmax + hy) && (ts <= tmax + BW'(tfh_pkg::BAND_MED))) begin
            fan_d = cfg.fan_duty_low;
        end else if ((ts > tmax + BW'(tfh_pkg::BAND_MED))
                  && (ts <= tmax + BW'(tfh_pkg::BAND_HIGH))) begin
            fan_d = cfg.fan_duty_med;
        end else if (ts >= tmax + BW'(tfh_pkg::BAND_FULL) - hy) begin
            fan_d = cfg.fan_duty_high;
        end else begin
            apply = 1'b0;
        end
    end

    // Next state
    always_comb begin
        sum_next    = sum_reg;
        vcount_next = vcount_reg;
        index_next  = index_reg;
        heater_next = heater_reg;
        fan_next    = fan_reg;
        kick_next   = kick_reg;
        temp_next   = temp_reg;
        error_next  = error_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quot_next   = quot_reg;
        load_out    = 1'b0;
        done_flag   = 1'b0;

        if (cmd.tick) begin
            if (kick_reg != '0) begin
                kick_next = kick_reg - 1'b1;
            end
            load_out = 1'b1;
        end

        if (cmd.sample) begin
            sum_next    = sum_reg + (sample_ok ? tfh_pkg::SUM_W'(s_sample) : '0);
            vcount_next = vcount_reg + tfh_pkg::COUNT_W'(sample_ok);
            index_next  = index_inc;
            load_out    = !status.last_sample;
        end

        if (cmd.mul_load) begin
            rem_next  = tfh_pkg::NUM_W'(sum_reg) * tfh_pkg::NUM_W'(tfh_pkg::TEMP_SCALE);
            dsh_next  = tfh_pkg::NUM_W'(den) << (tfh_pkg::QUOT_W - 1);
            quot_next = '0;
        end

        // Restoring division, one quotient bit per step
        if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_next  = rem_reg - dsh_reg;
                quot_next = {quot_reg[tfh_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[tfh_pkg::QUOT_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end

        if (cmd.finish) begin
            if (bad) begin
                error_next = 1'b1;
            end else begin
                error_next = 1'b0;
                temp_next  = quot_reg[tfh_pkg::TEMP_W-1:0];
            end
            if (apply) begin
                if (fan_d == '0) begin
                    kick_next = '0;
                end else if (fan_reg == '0) begin
                    kick_next = cfg.kick_ticks;
                end
                heater_next = heat_d;
                fan_next    = fan_d;
            end
            sum_next    = '0;
            vcount_next = '0;
            index_next  = '0;
            load_out    = 1'b1;
            done_flag   = 1'b1;
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            vcount_reg  <= '0;
            index_reg   <= '0;
            heater_reg  <= 1'b0;
            fan_reg     <= '0;
            kick_reg    <= '0;
            temp_reg    <= '0;
            error_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            vcount_reg  <= vcount_next;
            index_reg   <= index_next;
            heater_reg  <= heater_next;
            fan_reg     <= fan_next;
            kick_reg    <= kick_next;
            temp_reg    <= temp_next;
            error_reg   <= error_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Divider and result payload
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        if (load_out) begin
            out_heater_reg <= heater_next;
            out_fan_reg    <= (kick_next != '0) ? tfh_pkg::DUTY_W'(tfh_pkg::DUTY_FULL)
                                                : fan_next;
            out_temp_reg   <= temp_next;
            out_done_reg   <= done_flag;
            out_error_reg  <= error_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_heater_on          = out_heater_reg;
    assign m_fan_duty           = out_fan_reg;
    assign m_temperature_tenths = out_temp_reg;
    assign m_reading_done       = out_done_reg;
    assign m_sensor_error       = out_error_reg;

endmodule

/* rtl/thermostat_fan_heater_controller_top.sv */
// Tick and non-closing sample requests: result registered in the cycle after accept,
// one request per cycle while the result register drains.
// A sample that closes a reading: multiply, restoring divider (13 steps of one
// quotient bit), band decision on a free result register; no request taken meanwhile.
// Synchronous active-low reset: configuration returns to defaults, accumulators,
// heater, fan, kick counter, temperature and error flag clear, no result pending.
module thermostat_fan_heater_controller_top #(
    parameter int SAMPLES_PER_READING = tfh_pkg::SAMPLES_PER_READING
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Sample and tick requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [tfh_pkg::SAMPLE_W-1:0]       s_sample,
    // Results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_heater_on,
    output logic [tfh_pkg::DUTY_W-1:0]         m_fan_duty,
    output logic [tfh_pkg::TEMP_W-1:0]         m_temperature_tenths,
    output logic                               m_reading_done,
    output logic                               m_sensor_error,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tfh_pkg::cfg_t     cfg_reg;
    tfh_pkg::cmd_t     cmd;
    tfh_pkg::status_t  status;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.midpoint_deg        <= tfh_pkg::MID_W'(tfh_pkg::RST_MIDPOINT);
            cfg_reg.below_margin_tenths <= tfh_pkg::MARGIN_W'(tfh_pkg::RST_BELOW);
            cfg_reg.above_margin_tenths <= tfh_pkg::MARGIN_W'(tfh_pkg::RST_ABOVE);
            cfg_reg.hysteresis_tenths   <= tfh_pkg::HYST_W'(tfh_pkg::RST_HYSTERESIS);
            cfg_reg.fan_duty_low        <= tfh_pkg::DUTY_W'(tfh_pkg::RST_DUTY_LOW);
            cfg_reg.fan_duty_med        <= tfh_pkg::DUTY_W'(tfh_pkg::RST_DUTY_MED);
            cfg_reg.fan_duty_high       <= tfh_pkg::DUTY_W'(tfh_pkg::RST_DUTY_HIGH);
            cfg_reg.kick_ticks          <= tfh_pkg::KICK_W'(tfh_pkg::RST_KICK_TICKS);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tfh_pkg::REG_MIDPOINT:
                    cfg_reg.midpoint_deg <= cfg_data[tfh_pkg::MID_W-1:0];
                tfh_pkg::REG_BELOW:
                    cfg_reg.below_margin_tenths <= cfg_data[tfh_pkg::MARGIN_W-1:0];
                tfh_pkg::REG_ABOVE:
                    cfg_reg.above_margin_tenths <= cfg_data[tfh_pkg::MARGIN_W-1:0];
                tfh_pkg::REG_HYSTERESIS:
                    cfg_reg.hysteresis_tenths <= cfg_data[tfh_pkg::HYST_W-1:0];
                tfh_pkg::REG_DUTY_LOW:
                    cfg_reg.fan_duty_low <= cfg_data[tfh_pkg::DUTY_W-1:0];
                tfh_pkg::REG_DUTY_MED:
                    cfg_reg.fan_duty_med <= cfg_data[tfh_pkg::DUTY_W-1:0];
                tfh_pkg::REG_DUTY_HIGH:
                    cfg_reg.fan_duty_high <= cfg_data[tfh_pkg::DUTY_W-1:0];
                tfh_pkg::REG_KICK_TICKS:
                    cfg_reg.kick_ticks <= cfg_data[tfh_pkg::KICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tfh_dp #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg                  (cfg_reg),
        .s_sample             (s_sample),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_heater_on          (m_heater_on),
        .m_fan_duty           (m_fan_duty),
        .m_temperature_tenths (m_temperature_tenths),
        .m_reading_done       (m_reading_done),
        .m_sensor_error       (m_sensor_error)
    );

`ifndef SYNTHESIS
    // A sensor error leaves heater and fan off until a valid reading
    a_error_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sensor_error) |-> (!m_heater_on && (m_fan_duty == '0)))
        else $error("fan or heater driven during sensor error");

    // Heater and fan never run together
    a_heat_no_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_heater_on) |-> (m_fan_duty == '0))
        else $error("heater on with fan running");

    // Published temperature stays within the valid range
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_tenths <= tfh_pkg::TEMP_W'(tfh_pkg::TEMP_LIMIT)))
        else $error("temperature beyond limit");

    // A tick request produces its result in the next cycle
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func) |=> (m_valid && !m_reading_done))
        else $error("tick result missing");
`endif

endmodule

/* bench/tfh_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register channels, keeps its own copy of
// the thermostat state and compares every result with the predicted drive.
module tfh_checker
    import tfh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_func,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_heater_on,
    input  logic [DUTY_W-1:0]     m_fan_duty,
    input  logic [TEMP_W-1:0]     m_temperature_tenths,
    input  logic                  m_reading_done,
    input  logic                  m_sensor_error,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    readings_seen,
    output int                    bad_readings
);

    typedef struct packed {
        logic              heater_on;
        logic [DUTY_W-1:0] fan_duty;
        logic [TEMP_W-1:0] temperature;
        logic              done;
        logic              err;
    } drive_t;

    // Predicted drive per accepted request, oldest first
    drive_t drive_q[$];

    cfg_t                regs;
    logic [SUM_W-1:0]    acc_sum;
    logic [COUNT_W-1:0]  acc_valid;
    logic [COUNT_W-1:0]  acc_idx;
    logic                heat_st;
    logic [DUTY_W-1:0]   fan_lvl;
    logic [KICK_W-1:0]   kick_left;
    logic [TEMP_W-1:0]   last_temp;
    logic                err_st;

    function automatic void reset_state();
        regs.midpoint_deg        = MID_W'(RST_MIDPOINT);
        regs.below_margin_tenths = MARGIN_W'(RST_BELOW);
        regs.above_margin_tenths = MARGIN_W'(RST_ABOVE);
        regs.hysteresis_tenths   = HYST_W'(RST_HYSTERESIS);
        regs.fan_duty_low        = DUTY_W'(RST_DUTY_LOW);
        regs.fan_duty_med        = DUTY_W'(RST_DUTY_MED);
        regs.fan_duty_high       = DUTY_W'(RST_DUTY_HIGH);
        regs.kick_ticks          = KICK_W'(RST_KICK_TICKS);
        acc_sum   = '0;
        acc_valid = '0;
        acc_idx   = '0;
        heat_st   = 1'b0;
        fan_lvl   = '0;
        kick_left = '0;
        last_temp = '0;
        err_st    = 1'b0;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MIDPOINT:   regs.midpoint_deg        = d[MID_W-1:0];
            REG_BELOW:      regs.below_margin_tenths = d[MARGIN_W-1:0];
            REG_ABOVE:      regs.above_margin_tenths = d[MARGIN_W-1:0];
            REG_HYSTERESIS: regs.hysteresis_tenths   = d[HYST_W-1:0];
            REG_DUTY_LOW:   regs.fan_duty_low        = d[DUTY_W-1:0];
            REG_DUTY_MED:   regs.fan_duty_med        = d[DUTY_W-1:0];
            REG_DUTY_HIGH:  regs.fan_duty_high       = d[DUTY_W-1:0];
            REG_KICK_TICKS: regs.kick_ticks          = d[KICK_W-1:0];
            default: ;
        endcase
    endfunction

    // Fan start from zero loads the kick; fan off clears it
    function automatic void set_drive(logic heat, logic [DUTY_W-1:0] fan);
        if (fan == '0)
            kick_left = '0;
        else if (fan_lvl == '0)
            kick_left = regs.kick_ticks;
        heat_st = heat;
        fan_lvl = fan;
    endfunction

    // Band chain, first match wins; no match holds the outputs
    function automatic void pick_band(int t);
        int tmin;
        int tmax;
        int h;
        tmin = int'(regs.midpoint_deg) * DEG_TENTHS - int'(regs.below_margin_tenths);
        tmax = int'(regs.midpoint_deg) * DEG_TENTHS + int'(regs.above_margin_tenths);
        h    = int'(regs.hysteresis_tenths);
        if (t <= tmin - h)
            set_drive(1'b1, '0);
        else if (t > tmin + h && t <= tmax - h)
            set_drive(1'b0, '0);
        else if (t > tmax + h && t <= tmax + BAND_MED)
            set_drive(1'b0, regs.fan_duty_low);
        else if (t > tmax + BAND_MED && t <= tmax + BAND_HIGH)
            set_drive(1'b0, regs.fan_duty_med);
        else if (t >= tmax + BAND_FULL - h)
            set_drive(1'b0, regs.fan_duty_high);
    endfunction

    function automatic void close_reading();
        int unsigned num;
        int unsigned den;
        int unsigned t;
        logic        bad;
        bad = (acc_valid == '0);
        t   = 0;
        if (!bad) begin
            num = int'(acc_sum) * TEMP_SCALE;
            den = int'(acc_valid) * ADC_FULL;
            t   = num / den;
            if (t > TEMP_LIMIT)
                bad = 1'b1;
        end
        if (bad) begin
            err_st = 1'b1;
            set_drive(1'b0, '0);
            bad_readings++;
        end else begin
            err_st    = 1'b0;
            last_temp = t[TEMP_W-1:0];
            pick_band(int'(t));
        end
        acc_sum   = '0;
        acc_valid = '0;
        acc_idx   = '0;
        readings_seen++;
    endfunction

    function automatic drive_t step_item(logic func, logic [SAMPLE_W-1:0] smp);
        drive_t r;
        r.done = 1'b0;
        if (!func) begin
            // only samples strictly inside the converter's trusted range count
            if (smp > SAMPLE_MIN && smp < SAMPLE_MAX) begin
                acc_sum   = acc_sum + SUM_W'(smp);
                acc_valid = acc_valid + 1'b1;
            end
            acc_idx = acc_idx + 1'b1;
            if (acc_idx >= SAMPLES_PER_READING) begin
                close_reading();
                r.done = 1'b1;
            end
        end else if (kick_left != '0) begin
            kick_left = kick_left - 1'b1;
        end
        r.heater_on   = heat_st;
        r.fan_duty    = (kick_left != '0) ? DUTY_W'(DUTY_FULL) : fan_lvl;
        r.temperature = last_temp;
        r.err         = err_st;
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(drive_t w);
        cmp_field("heater_on", 16'(w.heater_on), 16'(m_heater_on));
        cmp_field("fan_duty", 16'(w.fan_duty), 16'(m_fan_duty));
        cmp_field("temperature_tenths", 16'(w.temperature), 16'(m_temperature_tenths));
        cmp_field("reading_done", 16'(w.done), 16'(m_reading_done));
        cmp_field("sensor_error", 16'(w.err), 16'(m_sensor_error));
    endfunction

    // Results are retired before the request of the same edge is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_state();
            drive_q.delete();
            fail_count    = 0;
            readings_seen = 0;
            bad_readings  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: result with no request outstanding, heater %0d fan %0d",
                             $time, m_heater_on, m_fan_duty);
                    fail_count++;
                end else begin
                    check_result(drive_q.pop_front());
                end
            end
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                drive_q.push_back(step_item(s_func, s_sample));
        end
        pending <= drive_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tfh_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 6;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = REG_KICK_TICKS + 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [SAMPLE_W-1:0]   s_sample;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_heater_on;
    logic [DUTY_W-1:0]     m_fan_duty;
    logic [TEMP_W-1:0]     m_temperature_tenths;
    logic                  m_reading_done;
    logic                  m_sensor_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int readings_seen;
    int bad_readings;
    int items_sent;
    int idle_cycles;
    int stall_left;
    int cur_kick;
    bit no_idle;
    bit gapless;
    bit long_hold_req;
    bit junk_bits;

    thermostat_fan_heater_controller_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_sample             (s_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_heater_on          (m_heater_on),
        .m_fan_duty           (m_fan_duty),
        .m_temperature_tenths (m_temperature_tenths),
        .m_reading_done       (m_reading_done),
        .m_sensor_error       (m_sensor_error),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    tfh_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_sample             (s_sample),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_heater_on          (m_heater_on),
        .m_fan_duty           (m_fan_duty),
        .m_temperature_tenths (m_temperature_tenths),
        .m_reading_done       (m_reading_done),
        .m_sensor_error       (m_sensor_error),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .fail_count           (fail_count),
        .pending              (pending),
        .readings_seen        (readings_seen),
        .bad_readings         (bad_readings)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure, with one long hold on request
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (long_hold_req) begin
                    stall_left    = LONG_HOLD;
                    long_hold_req = 1'b0;
                end else begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog: cycles without any accepted request, result or register write
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // valid stays high into the next request unless a gap is drawn
    task automatic send_item(bit func, logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_func   <= func;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d, int w);
        if (junk_bits && w < CFG_DATA_W)
            d = d | (CFG_DATA_W'($urandom) << w);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(cfg_t c, bit junk);
        junk_bits = junk;
        put_reg(REG_MIDPOINT, CFG_DATA_W'(c.midpoint_deg), MID_W);
        put_reg(REG_BELOW, CFG_DATA_W'(c.below_margin_tenths), MARGIN_W);
        put_reg(REG_ABOVE, CFG_DATA_W'(c.above_margin_tenths), MARGIN_W);
        put_reg(REG_HYSTERESIS, CFG_DATA_W'(c.hysteresis_tenths), HYST_W);
        put_reg(REG_DUTY_LOW, CFG_DATA_W'(c.fan_duty_low), DUTY_W);
        put_reg(REG_DUTY_MED, CFG_DATA_W'(c.fan_duty_med), DUTY_W);
        put_reg(REG_DUTY_HIGH, CFG_DATA_W'(c.fan_duty_high), DUTY_W);
        put_reg(REG_KICK_TICKS, CFG_DATA_W'(c.kick_ticks), KICK_W);
        // writes past the register map must leave everything untouched
        if (junk) begin
            put_reg(REG_UNUSED, CFG_DATA_W'($urandom), CFG_DATA_W);
            put_reg(REG_LAST_INDEX, CFG_DATA_W'($urandom), CFG_DATA_W);
        end
        cfg_valid <= 1'b0;
        junk_bits = 1'b0;
        cur_kick  = c.kick_ticks;
    endtask

    function automatic cfg_t phase_setting(int p);
        cfg_t c;
        case (p)
            0: c = '{6'd26, 8'd30, 8'd40, 6'd5, 8'd85, 8'd170, 8'd255, 10'd8};
            1: begin
                c = '0;
                c.midpoint_deg = 6'd10;
            end
            2: c = '{6'd50, 8'd200, 8'd200, 6'd50, 8'd255, 8'd255, 8'd255, 10'd1000};
            // beyond the stated ranges: overlapping bands
            4: c = '{6'd63, 8'd255, 8'd255, 6'd63, 8'($urandom), 8'($urandom),
                     8'($urandom), 10'd1023};
            default: begin
                c.midpoint_deg        = 6'($urandom_range(10, 50));
                c.below_margin_tenths = 8'($urandom_range(0, 200));
                c.above_margin_tenths = 8'($urandom_range(0, 200));
                c.hysteresis_tenths   = 6'($urandom_range(0, 50));
                c.fan_duty_low        = 8'($urandom);
                c.fan_duty_med        = 8'($urandom);
                c.fan_duty_high       = 8'($urandom);
                c.kick_ticks          = 10'($urandom_range(0, 12));
            end
        endcase
        return c;
    endfunction

    function automatic int span(int a, int b);
        int tmp;
        if (a > b) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        return a + int'($urandom_range(0, b - a));
    endfunction

    // Target temperature aimed at one of the bands or gaps
    function automatic int pick_target(int tmin, int tmax, int h);
        int t;
        case ($urandom_range(0, 8))
            0: t = tmin - h - int'($urandom_range(0, 80));
            1: t = tmin - h + int'($urandom_range(0, 2)) - 1;
            2: t = span(tmin - h, tmin + h);
            3: t = span(tmin + h, tmax - h);
            4: t = span(tmax - h, tmax + h);
            5: t = span(tmax + h, tmax + BAND_MED);
            6: t = span(tmax + BAND_MED, tmax + BAND_HIGH);
            7: t = span(tmax + BAND_FULL - h - 5, tmax + 400);
            default: t = tmax + BAND_HIGH + int'($urandom_range(0, 12)) - 6;
        endcase
        if (t < 0)
            t = 0;
        if (t > TEMP_LIMIT)
            t = TEMP_LIMIT;
        return t;
    endfunction

    // Valid raw reading close to a temperature
    function automatic int sample_for(int t);
        int s;
        s = (t * ADC_FULL + TEMP_SCALE / 2) / TEMP_SCALE + int'($urandom_range(0, 2)) - 1;
        if (s <= SAMPLE_MIN)
            s = SAMPLE_MIN + 1;
        if (s >= SAMPLE_MAX)
            s = SAMPLE_MAX - 1;
        return s;
    endfunction

    function automatic int invalid_sample();
        int r;
        r = $urandom_range(0, 7);
        return (r < 4) ? r : SAMPLE_MAX + r - 4;
    endfunction

    // One reading: 20 samples, ticks mixed in, sometimes a tick run after
    task automatic run_reading(cfg_t c);
        int tmin;
        int tmax;
        int t;
        int kind;
        int s;
        int n;
        tmin = int'(c.midpoint_deg) * DEG_TENTHS - int'(c.below_margin_tenths);
        tmax = int'(c.midpoint_deg) * DEG_TENTHS + int'(c.above_margin_tenths);
        t    = pick_target(tmin, tmax, int'(c.hysteresis_tenths));
        kind = $urandom_range(0, 99);
        for (int i = 0; i < SAMPLES_PER_READING; i++) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_item(1'b1, SAMPLE_W'($urandom));
            if (kind < 75)
                s = sample_for(t);
            else if (kind < 83)
                s = ($urandom_range(0, 3) == 0) ? invalid_sample() : sample_for(t);
            else if (kind < 89)
                s = invalid_sample();
            else if (kind < 94)
                s = $urandom_range(400, SAMPLE_MAX - 1);
            else
                s = $urandom_range(0, 1023);
            send_item(1'b0, s[SAMPLE_W-1:0]);
        end
        if ($urandom_range(0, 2) == 0) begin
            n = (cur_kick < 40) ? cur_kick + 1 : $urandom_range(1, 40);
            repeat (n) send_item(1'b1, SAMPLE_W'($urandom));
        end
    endtask

    initial begin
        cfg_t                c;
        logic [SAMPLE_W-1:0] corner_vals[10];
        int                  phase_end;
        bit                  paused;
        corner_vals = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd1019,
                        10'd1020, 10'd1021, 10'd1022, 10'd1023};
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = 1'b0;
        s_sample      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        gapless       = 1'b0;
        long_hold_req = 1'b0;
        junk_bits     = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;
        paused        = 1'b0;
        cur_kick      = RST_KICK_TICKS;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ticks with no kick, then one reading of range-edge samples,
        // only a few of them valid and far too hot, so a sensor error
        send_item(1'b1, '1);
        repeat (2)
            foreach (corner_vals[k])
                send_item(1'b0, corner_vals[k]);
        send_item(1'b1, '0);
        settle();

        // Random readings over several register settings
        for (int p = 0; p < PHASES; p++) begin
            c = phase_setting(p);
            configure(c, p == 4);
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            no_idle   = (p == 1);
            if (p == 2) begin
                gapless       = 1'b1;
                long_hold_req = 1'b1;
            end
            while (items_sent < phase_end) begin
                run_reading(c);
                gapless = 1'b0;
                if (p == 3 && !paused && items_sent >= phase_end - RANDOM_ITEMS / (2 * PHASES)) begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
            no_idle = 1'b0;
        end

        repeat (40) @(posedge aclk);
        $display("Sent %0d requests over %0d register settings: %0d readings, %0d sensor errors.",
                 items_sent, PHASES + 1, readings_seen, bad_readings);
        $display("Included a %0d-cycle result stall under steady input and a full drain pause.",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
